// ===== sv/srwfe_pkg.sv =====
// Shared types, constants and tables for the sound register write front end.
`default_nettype none

package srwfe_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int REG_WINDOW = 64;
  localparam int REG_AW     = $clog2(REG_WINDOW);
  localparam int LANES      = 4;
  localparam int ROW_AW     = REG_AW - 2;

  localparam logic [9:0] WIN_BASE    = 10'h060;
  localparam logic [9:0] WIN_LAST    = 10'h09F;
  localparam logic [9:0] OFF_VOL     = 10'h082;
  localparam logic [9:0] OFF_DS_CTRL = 10'h083;
  localparam logic [9:0] OFF_MASTER  = 10'h084;
  localparam logic [9:0] OFF_RAW_LO  = 10'h088;
  localparam logic [9:0] OFF_RAW_HI  = 10'h08B;
  localparam logic [9:0] OFF_UNGATED = 10'h090;
  localparam logic [9:0] OFF_FIFO_A  = 10'h0A0;
  localparam logic [9:0] OFF_FIFO_B_END = 10'h0A7;
  localparam logic [9:0] OFF_FWD_END = 10'h0AF;
  localparam logic [7:0] DS_CTRL_MASK = 8'h77;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_REG_RD  = 2'd1,
    REQ_FIFO_RD = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_FWD  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  localparam logic [7:0] REG_MASK [REG_WINDOW] = '{
    8'h7F, 8'h00, 8'hC0, 8'hFF, 8'h00, 8'h40, 8'h00, 8'h00,
    8'hC0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00,
    8'hE0, 8'h00, 8'h00, 8'hE0, 8'h00, 8'h40, 8'h00, 8'h00,
    8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h40, 8'h00, 8'h00,
    8'h77, 8'hFF, 8'h0F, 8'h77, 8'h80, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  typedef struct packed {
    logic               rd_en;
    logic [FIFO_AW-1:0] rd_addr;
    logic               wr_en;
    logic [31:0]        wr_val;
    logic [31:0]        wr_mask;
    logic               ptr_clr;
  } fifo_cmd_t;

  typedef struct packed {
    logic                        rd_en;
    logic [REG_AW-1:0]           rd_idx;
    logic [LANES-1:0]            wen;
    logic [LANES-1:0][REG_AW-1:0] widx;
    logic [LANES-1:0][7:0]       wdat;
  } reg_cmd_t;

  // fifo slot from the 3-bit index, wrapped at the ring depth
  function automatic logic [FIFO_AW-1:0] slot_of(input logic [2:0] idx);
    logic [FIFO_AW-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (idx == 3'(i)) r = FIFO_AW'(i % FIFO_DEPTH);
    end
    return r;
  endfunction

  function automatic logic [FIFO_AW-1:0] ring_next(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/srwfe_fifo.sv =====
// Direct-sound ring: word memory with byte-lane read-modify-write and write position.
`default_nettype none

module srwfe_fifo import srwfe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fifo_cmd_t          cmd,
  output logic [FIFO_AW-1:0]      ptr,
  output logic [31:0]             rdata
);

  logic [31:0]        mem [FIFO_DEPTH];
  logic               valid_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] ptr_r;
  logic [31:0]        rdat_r;
  logic               rvld_r;
  logic [31:0]        merged;

  assign rdata  = rvld_r ? rdat_r : '0;
  assign ptr    = ptr_r;
  assign merged = (rdata & ~cmd.wr_mask) | (cmd.wr_val & cmd.wr_mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      rvld_r <= 1'b0;
      for (int i = 0; i < FIFO_DEPTH; i++) valid_r[i] <= 1'b0;
    end else begin
      if (cmd.rd_en) rvld_r <= valid_r[cmd.rd_addr];
      if (cmd.ptr_clr) begin
        ptr_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[ptr_r] <= 1'b1;
        ptr_r          <= ring_next(ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdat_r <= mem[cmd.rd_addr];
    if (cmd.wr_en) mem[ptr_r] <= merged;
  end

endmodule

`default_nettype wire

// ===== sv/srwfe_regwin.sv =====
// Sound register window: four byte banks, one write per bank per cycle, one read.
`default_nettype none

module srwfe_regwin import srwfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire reg_cmd_t   cmd,
  output logic [7:0]      rdata
);

  logic [7:0]              mem [LANES][2**ROW_AW];
  logic                    valid_r [REG_WINDOW];
  logic [7:0]              rdat_r;
  logic                    rvld_r;
  logic [LANES-1:0]        bank_we;
  logic [ROW_AW-1:0]       bank_row [LANES];
  logic [7:0]              bank_dat [LANES];

  assign rdata = rvld_r ? rdat_r : '0;

  // consecutive bytes fall in distinct banks
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      bank_we[b]  = 1'b0;
      bank_row[b] = '0;
      bank_dat[b] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (cmd.wen[i] && cmd.widx[i][1:0] == 2'(b)) begin
          bank_we[b]  = 1'b1;
          bank_row[b] = cmd.widx[i][REG_AW-1:2];
          bank_dat[b] = cmd.wdat[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
      for (int i = 0; i < REG_WINDOW; i++) valid_r[i] <= 1'b0;
    end else begin
      if (cmd.rd_en) rvld_r <= valid_r[cmd.rd_idx];
      for (int i = 0; i < LANES; i++) begin
        if (cmd.wen[i]) valid_r[cmd.widx[i]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdat_r <= mem[cmd.rd_idx[1:0]][cmd.rd_idx[REG_AW-1:2]];
    for (int b = 0; b < LANES; b++) begin
      if (bank_we[b]) mem[b][bank_row[b]] <= bank_dat[b];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sound_register_write_front_end_core.sv =====
// Top level: request sequencer, write decode and result register of the sound front end.
//
// One bus access is taken when start is high and busy is low. Its first result
// beat appears on the out_ ports, marked by out_valid, from the result registers
// loaded in the execute state that follows acceptance; a word write to the sound
// registers gives a second beat in the cycle that follows. The block takes no new
// access while busy, i.e. in the execute and high-half states: the state lives in
// synchronous memories (two fifo rings, a banked register window) read in the accept
// cycle and written back in the cycle after. The receiver cannot stall: every beat
// is on the ports for one cycle only. No clearing pass is needed after reset.
`default_nettype none

module sound_register_write_front_end_core import srwfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [9:0]  in_io_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [1:0]  in_access_size,
  input  wire logic [2:0]  in_fifo_index,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_fwd_offset,
  output logic [15:0]      out_fwd_data,
  output logic             out_fwd_wide,
  output logic [31:0]      out_read_data,
  output logic             out_master_on,
  output logic [2:0]       out_fifo_a_pos,
  output logic [2:0]       out_fifo_b_pos,
  output logic             out_last
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_HIGH} state_t;

  state_t      state_r;
  state_t      state_nxt;
  req_t        req_r;
  logic [9:0]  off_r;
  logic [31:0] data_r;
  logic [1:0]  size_r;
  logic        enable_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_fwd_offset_r;
  logic [15:0] out_fwd_data_r;
  logic        out_fwd_wide_r;
  logic [31:0] out_read_data_r;
  logic        out_master_on_r;
  logic [2:0]  out_fifo_a_pos_r;
  logic [2:0]  out_fifo_b_pos_r;
  logic        out_last_r;

  logic        out_valid_nxt;
  logic [1:0]  out_kind_nxt;
  logic [7:0]  out_fwd_offset_nxt;
  logic [15:0] out_fwd_data_nxt;
  logic        out_fwd_wide_nxt;
  logic [31:0] out_read_data_nxt;
  logic        out_master_on_nxt;
  logic [2:0]  out_fifo_a_pos_nxt;
  logic [2:0]  out_fifo_b_pos_nxt;
  logic        out_last_nxt;

  logic               accept;
  logic               exec;
  logic               is_word;
  logic               is_fifo_port;
  logic               is_fwd;
  logic               in_rd_win;
  logic [REG_AW-1:0]  rd_diff;
  logic [4:0]         sh;
  logic               enable_nxt;
  logic               clr_a;
  logic               clr_b;
  logic [FIFO_AW-1:0] ptr_a;
  logic [FIFO_AW-1:0] ptr_b;
  logic [FIFO_AW-1:0] pos_a_nxt;
  logic [FIFO_AW-1:0] pos_b_nxt;
  logic [31:0]        fifo_a_rd;
  logic [31:0]        fifo_b_rd;
  logic [7:0]         reg_rd;
  logic [31:0]        fifo_val;
  logic [31:0]        fifo_mask;
  fifo_cmd_t          cmd_a;
  fifo_cmd_t          cmd_b;
  reg_cmd_t           cmd_win;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign exec    = (state_r == ST_EXEC);
  assign is_word = (size_r != SIZE_BYTE) && (size_r != SIZE_HALF);
  assign is_fifo_port = (req_r == REQ_WRITE) && off_r >= OFF_FIFO_A && off_r <= OFF_FIFO_B_END;
  assign is_fwd  = (req_r == REQ_WRITE) && off_r >= WIN_BASE && off_r <= OFF_FWD_END
                   && !is_fifo_port;
  assign in_rd_win = off_r >= WIN_BASE && off_r <= WIN_LAST;
  assign rd_diff = REG_AW'(in_io_offset - WIN_BASE);
  assign sh      = {off_r[1:0], 3'b000};

  always_comb begin
    fifo_mask = is_word ? 32'hFFFF_FFFF
              : ((size_r == SIZE_BYTE ? 32'h0000_00FF : 32'h0000_FFFF) << sh);
    fifo_val  = is_word ? data_r : (data_r << sh);
  end

  // byte-by-byte store into the window; the master enable can change mid-write
  always_comb begin
    logic [9:0] a;
    logic [7:0] b;
    logic       used;
    logic       en_v;
    en_v  = enable_r;
    clr_a = 1'b0;
    clr_b = 1'b0;
    cmd_win.rd_en  = accept;
    cmd_win.rd_idx = rd_diff;
    cmd_win.wen    = '0;
    cmd_win.widx   = '0;
    cmd_win.wdat   = '0;
    for (int i = 0; i < LANES; i++) begin
      a    = off_r + 10'(i);
      b    = data_r[8*i +: 8];
      used = (i == 0) || (i == 1 && size_r != SIZE_BYTE) || (i >= 2 && is_word);
      cmd_win.widx[i] = REG_AW'(a - WIN_BASE);
      if (exec && is_fwd && used && a >= WIN_BASE && a <= WIN_LAST) begin
        if (a == OFF_VOL || (a >= OFF_RAW_LO && a <= OFF_RAW_HI)) begin
          cmd_win.wen[i]  = 1'b1;
          cmd_win.wdat[i] = b;
        end else if (a == OFF_DS_CTRL) begin
          cmd_win.wen[i]  = 1'b1;
          cmd_win.wdat[i] = b & DS_CTRL_MASK;
          clr_a = clr_a | b[3];
          clr_b = clr_b | b[7];
        end else if (a == OFF_MASTER) begin
          en_v = b[7];
          cmd_win.wen[i]  = 1'b1;
          cmd_win.wdat[i] = {b[7], 7'b0};
        end else if (en_v || a >= OFF_UNGATED) begin
          cmd_win.wen[i]  = 1'b1;
          cmd_win.wdat[i] = b & REG_MASK[cmd_win.widx[i]];
        end
      end
    end
    enable_nxt = en_v;
  end

  always_comb begin
    cmd_a.rd_en   = accept;
    cmd_a.rd_addr = (req_t'(in_req_type) == REQ_FIFO_RD) ? slot_of(in_fifo_index) : ptr_a;
    cmd_a.wr_en   = exec && is_fifo_port && !off_r[2];
    cmd_a.wr_val  = fifo_val;
    cmd_a.wr_mask = fifo_mask;
    cmd_a.ptr_clr = clr_a;
    cmd_b.rd_en   = accept;
    cmd_b.rd_addr = (req_t'(in_req_type) == REQ_FIFO_RD) ? slot_of(in_fifo_index) : ptr_b;
    cmd_b.wr_en   = exec && is_fifo_port && off_r[2];
    cmd_b.wr_val  = fifo_val;
    cmd_b.wr_mask = fifo_mask;
    cmd_b.ptr_clr = clr_b;
    pos_a_nxt = clr_a ? '0 : (cmd_a.wr_en ? ring_next(ptr_a) : ptr_a);
    pos_b_nxt = clr_b ? '0 : (cmd_b.wr_en ? ring_next(ptr_b) : ptr_b);
  end

  srwfe_fifo u_fifo_a (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_a),
    .ptr   (ptr_a),
    .rdata (fifo_a_rd)
  );

  srwfe_fifo u_fifo_b (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_b),
    .ptr   (ptr_b),
    .rdata (fifo_b_rd)
  );

  srwfe_regwin u_regwin (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_win),
    .rdata (reg_rd)
  );

  always_comb begin
    state_nxt          = state_r;
    out_valid_nxt      = 1'b0;
    out_kind_nxt       = out_kind_r;
    out_fwd_offset_nxt = out_fwd_offset_r;
    out_fwd_data_nxt   = out_fwd_data_r;
    out_fwd_wide_nxt   = out_fwd_wide_r;
    out_read_data_nxt  = out_read_data_r;
    out_master_on_nxt  = out_master_on_r;
    out_fifo_a_pos_nxt = out_fifo_a_pos_r;
    out_fifo_b_pos_nxt = out_fifo_b_pos_r;
    out_last_nxt       = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        out_valid_nxt      = 1'b1;
        out_kind_nxt       = KIND_DONE;
        out_fwd_offset_nxt = '0;
        out_fwd_data_nxt   = '0;
        out_fwd_wide_nxt   = 1'b0;
        out_read_data_nxt  = '0;
        out_master_on_nxt  = enable_nxt;
        out_fifo_a_pos_nxt = 3'(pos_a_nxt);
        out_fifo_b_pos_nxt = 3'(pos_b_nxt);
        out_last_nxt       = 1'b1;
        state_nxt          = ST_IDLE;
        case (req_r)
          REQ_REG_RD: begin
            out_kind_nxt      = KIND_READ;
            out_read_data_nxt = in_rd_win ? {24'b0, reg_rd} : '0;
          end
          REQ_FIFO_RD: begin
            out_kind_nxt      = KIND_READ;
            out_read_data_nxt = off_r[2] ? fifo_b_rd : fifo_a_rd;
          end
          REQ_WRITE: begin
            if (is_fwd) begin
              out_kind_nxt       = KIND_FWD;
              out_fwd_offset_nxt = off_r[7:0];
              out_fwd_data_nxt   = (size_r == SIZE_BYTE) ? {8'b0, data_r[7:0]}
                                                         : data_r[15:0];
              out_fwd_wide_nxt   = (size_r != SIZE_BYTE);
              out_last_nxt       = !is_word;
              if (is_word) state_nxt = ST_HIGH;
            end
          end
          default: begin
            out_kind_nxt = KIND_DONE;
          end
        endcase
      end
      ST_HIGH: begin
        out_valid_nxt      = 1'b1;
        out_kind_nxt       = KIND_FWD;
        out_fwd_offset_nxt = off_r[7:0] + 8'd2;
        out_fwd_data_nxt   = data_r[31:16];
        out_fwd_wide_nxt   = 1'b1;
        out_read_data_nxt  = '0;
        out_master_on_nxt  = enable_r;
        out_fifo_a_pos_nxt = 3'(ptr_a);
        out_fifo_b_pos_nxt = 3'(ptr_b);
        out_last_nxt       = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        req_r  <= req_t'(in_req_type);
        off_r  <= in_io_offset;
        data_r <= in_write_data;
        size_r <= in_access_size;
      end
      state_r          <= state_nxt;
      enable_r         <= enable_nxt;
      out_valid_r      <= out_valid_nxt;
      out_kind_r       <= out_kind_nxt;
      out_fwd_offset_r <= out_fwd_offset_nxt;
      out_fwd_data_r   <= out_fwd_data_nxt;
      out_fwd_wide_r   <= out_fwd_wide_nxt;
      out_read_data_r  <= out_read_data_nxt;
      out_master_on_r  <= out_master_on_nxt;
      out_fifo_a_pos_r <= out_fifo_a_pos_nxt;
      out_fifo_b_pos_r <= out_fifo_b_pos_nxt;
      out_last_r       <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_fwd_offset = out_fwd_offset_r;
  assign out_fwd_data   = out_fwd_data_r;
  assign out_fwd_wide   = out_fwd_wide_r;
  assign out_read_data  = out_read_data_r;
  assign out_master_on  = out_master_on_r;
  assign out_fifo_a_pos = out_fifo_a_pos_r;
  assign out_fifo_b_pos = out_fifo_b_pos_r;
  assign out_last       = out_last_r;

  a_high_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_last && out_kind == KIND_FWD)
    else $error("second forwarded beat missing");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted beat did not hold the block busy");

  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_READ |-> out_last && out_fwd_data == 16'h0000)
    else $error("read result not a single clean beat");

  a_valid_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a request in flight");

endmodule

`default_nettype wire
